// ----- design/mae_pkg.sv -----
// mae_pkg: shared types and codes for the mips subset alu execute block
// opcode and function codes, status codes and the execute result struct
// no dependencies
`default_nettype none

package mae_pkg;

  localparam int REG_COUNT  = 32;
  localparam int DATA_WIDTH = 32;
  localparam int REG_AW     = $clog2(REG_COUNT);

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [REG_AW-1:0]     reg_idx_t;
  typedef logic [1:0]            status_t;

  // status codes
  localparam status_t ST_EXEC       = 2'd0;
  localparam status_t ST_HALT       = 2'd1;
  localparam status_t ST_NOTHANDLED = 2'd2;
  localparam status_t ST_UNKNOWN    = 2'd3;

  // primary opcodes
  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_J     = 6'd2;
  localparam logic [5:0] OP_JAL   = 6'd3;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_BNE   = 6'd5;
  localparam logic [5:0] OP_BGTZ  = 6'd7;
  localparam logic [5:0] OP_ADDI  = 6'd8;
  localparam logic [5:0] OP_ADDIU = 6'd9;
  localparam logic [5:0] OP_SLTI  = 6'd10;
  localparam logic [5:0] OP_ANDI  = 6'd12;
  localparam logic [5:0] OP_ORI   = 6'd13;
  localparam logic [5:0] OP_NORI  = 6'd14;
  localparam logic [5:0] OP_LUI   = 6'd15;
  localparam logic [5:0] OP_LB    = 6'd32;
  localparam logic [5:0] OP_LH    = 6'd33;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_LBU   = 6'd36;
  localparam logic [5:0] OP_LHU   = 6'd37;
  localparam logic [5:0] OP_SB    = 6'd40;
  localparam logic [5:0] OP_SH    = 6'd41;
  localparam logic [5:0] OP_SW    = 6'd43;
  localparam logic [5:0] OP_HALT  = 6'd63;

  // r-type function codes
  localparam logic [5:0] FN_SLL  = 6'd0;
  localparam logic [5:0] FN_SRL  = 6'd2;
  localparam logic [5:0] FN_SRA  = 6'd3;
  localparam logic [5:0] FN_JR   = 6'd8;
  localparam logic [5:0] FN_ADD  = 6'd32;
  localparam logic [5:0] FN_ADDU = 6'd33;
  localparam logic [5:0] FN_SUB  = 6'd34;
  localparam logic [5:0] FN_AND  = 6'd36;
  localparam logic [5:0] FN_OR   = 6'd37;
  localparam logic [5:0] FN_XOR  = 6'd38;
  localparam logic [5:0] FN_NOR  = 6'd39;
  localparam logic [5:0] FN_NAND = 6'd40;
  localparam logic [5:0] FN_SLT  = 6'd42;

  // one executed instruction, plus the state updates it asks for
  typedef struct packed {
    word_t    instr_address;
    reg_idx_t dest_reg;
    word_t    write_value;
    logic     write_enable;
    status_t  status;
    logic     overflow_flag;
    logic     zero_write_flag;
    logic     pc_wrap_flag;
    logic     adv_pc;
    logic     set_halt;
  } exec_result_t;

endpackage

`default_nettype wire

// ----- design/mae_if.sv -----
// mae_in_if and mae_out_if: valid/ready channels of the execute block
// depends on mae_pkg for the field types
`default_nettype none

interface mae_in_if;
  import mae_pkg::*;

  logic  valid;
  logic  ready;
  word_t instruction_word;

  modport source (output valid, output instruction_word, input ready);
  modport sink (input valid, input instruction_word, output ready);
endinterface

interface mae_out_if;
  import mae_pkg::*;

  logic     valid;
  logic     ready;
  word_t    instr_address;
  reg_idx_t dest_reg;
  word_t    write_value;
  logic     write_enable;
  status_t  status;
  logic     overflow_flag;
  logic     zero_write_flag;
  logic     pc_wrap_flag;

  modport source (output valid, output instr_address, output dest_reg,
                  output write_value, output write_enable, output status,
                  output overflow_flag, output zero_write_flag,
                  output pc_wrap_flag, input ready);
  modport sink (input valid, input instr_address, input dest_reg,
                input write_value, input write_enable, input status,
                input overflow_flag, input zero_write_flag,
                input pc_wrap_flag, output ready);
endinterface

`default_nettype wire

// ----- design/mae_regfile.sv -----
// mae_regfile: 32 x 32 register file, one write port, two registered read ports
// write-through bypass on a same-edge write; per-entry valid bits read as zero
// depends on mae_pkg
`default_nettype none

module mae_regfile (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 wr_en,
  input  mae_pkg::reg_idx_t   wr_addr,
  input  mae_pkg::word_t      wr_data,
  input  wire                 rd_en,
  input  mae_pkg::reg_idx_t   rd_addr_a,
  input  mae_pkg::reg_idx_t   rd_addr_b,
  output mae_pkg::word_t      rd_data_a,
  output mae_pkg::word_t      rd_data_b
);
  import mae_pkg::*;

  word_t                mem [REG_COUNT];
  logic [REG_COUNT-1:0] valid_r;
  word_t                rd_a_r;
  word_t                rd_b_r;

  // storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // entries hold reset value zero until first written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // registered reads, a write on the same edge goes straight through
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && wr_addr == rd_addr_a) begin
        rd_a_r <= wr_data;
      end else begin
        rd_a_r <= valid_r[rd_addr_a] ? mem[rd_addr_a] : '0;
      end
      if (wr_en && wr_addr == rd_addr_b) begin
        rd_b_r <= wr_data;
      end else begin
        rd_b_r <= valid_r[rd_addr_b] ? mem[rd_addr_b] : '0;
      end
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

`default_nettype wire

// ----- design/mae_alu.sv -----
// mae_alu: decode and execute of one instruction, purely combinational
// takes the instruction, both operands, program counter and halted flag
// depends on mae_pkg
`default_nettype none

module mae_alu (
  input  mae_pkg::word_t        instr,
  input  mae_pkg::word_t        op_a,
  input  mae_pkg::word_t        op_b,
  input  mae_pkg::word_t        pc,
  input  wire                   halted,
  output mae_pkg::exec_result_t res
);
  import mae_pkg::*;

  logic [5:0]  opcode;
  logic [5:0]  funct;
  logic [4:0]  shamt;
  reg_idx_t    rt;
  reg_idx_t    rd;
  word_t       imm_s;
  word_t       imm_z;
  word_t       sum_ab;
  word_t       diff_ab;
  word_t       sum_ai;
  logic [32:0] pc_inc;
  word_t       val;
  reg_idx_t    dest;
  logic        ovf;
  logic        writes;
  status_t     status;

  // instruction fields
  assign opcode = instr[31:26];
  assign rt     = instr[20:16];
  assign rd     = instr[15:11];
  assign shamt  = instr[10:6];
  assign funct  = instr[5:0];
  assign imm_s  = {{16{instr[15]}}, instr[15:0]};
  assign imm_z  = {16'b0, instr[15:0]};

  // shared adders
  assign sum_ab  = op_a + op_b;
  assign diff_ab = op_a - op_b;
  assign sum_ai  = op_a + imm_s;
  assign pc_inc  = {1'b0, pc} + 33'd4;

  // decode and execute
  always_comb begin
    val    = '0;
    dest   = '0;
    ovf    = 1'b0;
    writes = 1'b0;
    status = ST_EXEC;
    unique case (opcode)
      OP_RTYPE: begin
        writes = 1'b1;
        dest   = rd;
        unique case (funct)
          FN_ADD: begin
            val = sum_ab;
            ovf = (op_a[31] ^ sum_ab[31]) & (op_b[31] ^ sum_ab[31]);
          end
          FN_ADDU: val = sum_ab;
          FN_SUB: begin
            val = diff_ab;
            ovf = (op_a[31] ^ op_b[31]) & (op_a[31] ^ diff_ab[31]);
          end
          FN_AND:  val = op_a & op_b;
          FN_OR:   val = op_a | op_b;
          FN_XOR:  val = op_a ^ op_b;
          FN_NOR:  val = ~(op_a | op_b);
          FN_NAND: val = ~(op_a & op_b);
          FN_SLT:  val = {31'b0, $signed(op_a) < $signed(op_b)};
          FN_SLL:  val = op_b << shamt;
          FN_SRL:  val = op_b >> shamt;
          FN_SRA:  val = word_t'($signed(op_b) >>> shamt);
          FN_JR: begin
            writes = 1'b0;
            status = ST_NOTHANDLED;
          end
          default: begin
            writes = 1'b0;
            status = ST_UNKNOWN;
          end
        endcase
      end
      OP_ADDI: begin
        writes = 1'b1;
        dest   = rt;
        val    = sum_ai;
        ovf    = (op_a[31] ^ sum_ai[31]) & (imm_s[31] ^ sum_ai[31]);
      end
      OP_ADDIU: begin
        writes = 1'b1;
        dest   = rt;
        val    = sum_ai;
      end
      OP_ANDI: begin
        writes = 1'b1;
        dest   = rt;
        val    = op_a & imm_z;
      end
      OP_ORI: begin
        writes = 1'b1;
        dest   = rt;
        val    = op_a | imm_z;
      end
      OP_NORI: begin
        writes = 1'b1;
        dest   = rt;
        val    = ~(op_a | imm_z);
      end
      OP_SLTI: begin
        writes = 1'b1;
        dest   = rt;
        val    = {31'b0, $signed(op_a) < $signed(imm_s)};
      end
      OP_HALT: status = ST_HALT;
      OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BGTZ, OP_LUI, OP_LB, OP_LH, OP_LW,
      OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW: status = ST_NOTHANDLED;
      default: status = ST_UNKNOWN;
    endcase
  end

  // result assembly, a halted core reports only halt status at its held address
  always_comb begin
    res.instr_address = pc;
    if (halted) begin
      res.dest_reg        = '0;
      res.write_value     = '0;
      res.write_enable    = 1'b0;
      res.status          = ST_HALT;
      res.overflow_flag   = 1'b0;
      res.zero_write_flag = 1'b0;
      res.pc_wrap_flag    = 1'b0;
      res.adv_pc          = 1'b0;
      res.set_halt        = 1'b0;
    end else begin
      res.dest_reg        = writes ? dest : '0;
      res.write_value     = writes ? val : '0;
      res.write_enable    = writes && (dest != '0);
      res.status          = status;
      res.overflow_flag   = writes & ovf;
      res.zero_write_flag = writes && (dest == '0);
      res.pc_wrap_flag    = pc_inc[32];
      res.adv_pc          = 1'b1;
      res.set_halt        = (status == ST_HALT);
    end
  end

endmodule

`default_nettype wire

// ----- design/mips_subset_alu_execute.sv -----
// Execute unit for a MIPS32 integer ALU subset: one instruction word per input
// beat, one result beat per instruction. The register file is read into the operand
// stage at acceptance, then decode, execute and write-back go into the result
// register as the operand stage advances; a stalled result beat holds both stages,
// and a new instruction is accepted every cycle while the result beat is not
// stalled; back-to-back dependent instructions run at full rate through the
// register file's write-through read. The program
// counter starts at the value written on the cfg port (zero after reset) and
// advances by 4 per instruction until a halt, after which every beat reports
// halt at the held address. No clearing pass is needed after reset.
// depends on mae_pkg, mae_if, mae_regfile and mae_alu
`default_nettype none

module mips_subset_alu_execute (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             cfg_we,
  input  mae_pkg::word_t  cfg_wdata,
  mae_in_if.sink          in_ch,
  mae_out_if.source       out_ch
);
  import mae_pkg::*;

  logic         s1_valid_r;
  word_t        s1_instr_r;
  logic         s1_adv;
  logic         in_accept;
  word_t        op_a;
  word_t        op_b;
  exec_result_t res;
  word_t        pc_r;
  logic         halted_r;
  logic         out_valid_r;
  exec_result_t out_res_r;

  // handshake: the operand stage moves on whenever the result register frees
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_accept   = in_ch.valid && in_ch.ready;

  // operand stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_instr_r <= in_ch.instruction_word;
    end
  end

  // register file, read on accept, written as an instruction retires
  mae_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (s1_adv && res.write_enable),
    .wr_addr   (res.dest_reg),
    .wr_data   (res.write_value),
    .rd_en     (in_accept),
    .rd_addr_a (in_ch.instruction_word[25:21]),
    .rd_addr_b (in_ch.instruction_word[20:16]),
    .rd_data_a (op_a),
    .rd_data_b (op_b)
  );

  // decode and execute
  mae_alu u_alu (
    .instr  (s1_instr_r),
    .op_a   (op_a),
    .op_b   (op_b),
    .pc     (pc_r),
    .halted (halted_r),
    .res    (res)
  );

  // program counter and halt state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= '0;
      halted_r <= 1'b0;
    end else if (cfg_we) begin
      pc_r <= cfg_wdata;
    end else if (s1_adv) begin
      if (res.adv_pc) begin
        pc_r <= pc_r + 32'd4;
      end
      if (res.set_halt) begin
        halted_r <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  // result beat
  assign out_ch.valid           = out_valid_r;
  assign out_ch.instr_address   = out_res_r.instr_address;
  assign out_ch.dest_reg        = out_res_r.dest_reg;
  assign out_ch.write_value     = out_res_r.write_value;
  assign out_ch.write_enable    = out_res_r.write_enable;
  assign out_ch.status          = out_res_r.status;
  assign out_ch.overflow_flag   = out_res_r.overflow_flag;
  assign out_ch.zero_write_flag = out_res_r.zero_write_flag;
  assign out_ch.pc_wrap_flag    = out_res_r.pc_wrap_flag;

endmodule

`default_nettype wire
